// File: design/mrfd_pkg.sv
`default_nettype none

package mrfd_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned PayloadFirst = 3;
  localparam int unsigned PayloadLen   = 20;
  localparam int unsigned MinFrame     = 25;
  localparam int unsigned IdxW         = 6;
  localparam logic [IdxW-1:0] IndexMax = 6'd63;

  // Frame positions of the 16-bit words; 32-bit values put the low word first.
  localparam int unsigned PosVoltage   = 3;
  localparam int unsigned PosCurrent   = 5;
  localparam int unsigned PosPower     = 9;
  localparam int unsigned PosEnergy    = 13;
  localparam int unsigned PosFrequency = 17;
  localparam int unsigned PosPfactor   = 19;
  localparam int unsigned PosAlarm     = 21;

  typedef logic [PayloadLen-1:0][7:0] payload_t;

  typedef struct packed {
    logic crc_ok;
    logic len_ok;
  } mrfd_status_t;

  // Reflected CRC-16, one byte folded in bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Big-endian 16-bit word at a frame position inside the payload.
  function automatic logic [15:0] word16(input payload_t p, input int unsigned pos);
    return {p[pos-PayloadFirst], p[pos-PayloadFirst+1]};
  endfunction

  function automatic logic [31:0] word32(input payload_t p, input int unsigned pos);
    return {word16(p, pos + 2), word16(p, pos)};
  endfunction

endpackage

`default_nettype wire

// File: design/mrfd_track.sv
`default_nettype none

module mrfd_track (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic                  last_byte_i,
  output mrfd_pkg::mrfd_status_t     status_o,
  output mrfd_pkg::payload_t         payload_o
);
  import mrfd_pkg::*;

  logic [15:0]     crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  payload_t        payload_q;

  assign crc_d = crc_byte(crc_q, rx_byte_i);

  always_comb begin
    if (last_byte_i) begin
      idx_d = '0;
    end else if (idx_q < IndexMax) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
      idx_q <= '0;
    end else if (fire_i) begin
      crc_q <= last_byte_i ? CrcInit : crc_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PayloadLen; i++) begin
      if (fire_i && idx_q == IdxW'(i + PayloadFirst)) begin
        payload_q[i] <= rx_byte_i;
      end
    end
  end

  // The length test looks at the position of the byte now arriving.
  assign status_o.crc_ok = (crc_d == 16'h0000);
  assign status_o.len_ok = (idx_q >= IdxW'(MinFrame - 1));
  assign payload_o       = payload_q;

endmodule

`default_nettype wire

// File: design/mrfd_result.sv
`default_nettype none

module mrfd_result (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire mrfd_pkg::mrfd_status_t status_i,
  input  wire mrfd_pkg::payload_t     payload_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [15:0]                voltage_decivolt_o,
  output logic [31:0]                current_milliamp_o,
  output logic [31:0]                power_deciwatt_o,
  output logic [31:0]                energy_watt_hour_o,
  output logic [15:0]                frequency_decihertz_o,
  output logic [15:0]                power_factor_hundredths_o,
  output logic [15:0]                alarm_word_o,
  output logic                       update_ok_o
);
  import mrfd_pkg::*;

  logic        valid_q;
  logic        ok;
  logic [15:0] volt_q, freq_q, pf_q, alarm_q;
  logic [31:0] curr_q, pwr_q, energy_q;
  logic        ok_q;

  assign ok = status_i.crc_ok && status_i.len_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      volt_q   <= ok ? word16(payload_i, PosVoltage)   : '0;
      curr_q   <= ok ? word32(payload_i, PosCurrent)   : '0;
      pwr_q    <= ok ? word32(payload_i, PosPower)     : '0;
      energy_q <= ok ? word32(payload_i, PosEnergy)    : '0;
      freq_q   <= ok ? word16(payload_i, PosFrequency) : '0;
      pf_q     <= ok ? word16(payload_i, PosPfactor)   : '0;
      alarm_q  <= ok ? word16(payload_i, PosAlarm)     : '0;
      ok_q     <= ok;
    end
  end

  assign out_valid_o               = valid_q;
  assign voltage_decivolt_o        = volt_q;
  assign current_milliamp_o        = curr_q;
  assign power_deciwatt_o          = pwr_q;
  assign energy_watt_hour_o        = energy_q;
  assign frequency_decihertz_o     = freq_q;
  assign power_factor_hundredths_o = pf_q;
  assign alarm_word_o              = alarm_q;
  assign update_ok_o               = ok_q;

endmodule

`default_nettype wire

// File: design/meter_response_frame_decoder.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o | rx_byte_i, last_byte_i
// out      | out_valid_o/ out_ready_i| measurement fields, update_ok_o
//
// One byte is taken every cycle while in_ready_o is high; the CRC and byte position update at the transfer.
// The result of a frame appears in the cycle after its last byte is taken, from the result register.
// Input stalls only while a result waits and out_ready_i is low.
// Reset loads the CRC with all ones and clears the byte position; payload bytes are
// not reset.
`default_nettype none

module meter_response_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      voltage_decivolt_o,
  output logic [31:0]      current_milliamp_o,
  output logic [31:0]      power_deciwatt_o,
  output logic [31:0]      energy_watt_hour_o,
  output logic [15:0]      frequency_decihertz_o,
  output logic [15:0]      power_factor_hundredths_o,
  output logic [15:0]      alarm_word_o,
  output logic             update_ok_o
);
  import mrfd_pkg::*;

  logic         fire;
  mrfd_status_t status;
  payload_t     payload;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  mrfd_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_i),
    .last_byte_i (last_byte_i),
    .status_o    (status),
    .payload_o   (payload)
  );

  mrfd_result u_result (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .load_i                    (fire && last_byte_i),
    .status_i                  (status),
    .payload_i                 (payload),
    .out_ready_i               (out_ready_i),
    .out_valid_o               (out_valid_o),
    .voltage_decivolt_o        (voltage_decivolt_o),
    .current_milliamp_o        (current_milliamp_o),
    .power_deciwatt_o          (power_deciwatt_o),
    .energy_watt_hour_o        (energy_watt_hour_o),
    .frequency_decihertz_o     (frequency_decihertz_o),
    .power_factor_hundredths_o (power_factor_hundredths_o),
    .alarm_word_o              (alarm_word_o),
    .update_ok_o               (update_ok_o)
  );

endmodule

`default_nettype wire

// File: design/mrfd_checker.sv
`default_nettype none

module mrfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] voltage_decivolt_o,
  input wire logic [31:0] current_milliamp_o,
  input wire logic [31:0] power_deciwatt_o,
  input wire logic [31:0] energy_watt_hour_o,
  input wire logic [15:0] frequency_decihertz_o,
  input wire logic [15:0] power_factor_hundredths_o,
  input wire logic [15:0] alarm_word_o,
  input wire logic        update_ok_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // A waiting result holds still until its transfer (valid, update_ok, voltage, current, energy, alarm).
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(update_ok_o)
      && $stable(voltage_decivolt_o) && $stable(current_milliamp_o)
      && $stable(energy_watt_hour_o) && $stable(alarm_word_o))
    else $error("result changed while stalled");

  // A failed frame reports only zeros.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !update_ok_o |-> voltage_decivolt_o == 16'h0
      && current_milliamp_o == 32'h0 && power_deciwatt_o == 32'h0
      && energy_watt_hour_o == 32'h0 && frequency_decihertz_o == 16'h0
      && power_factor_hundredths_o == 16'h0 && alarm_word_o == 16'h0)
    else $error("failed frame has nonzero values");

  // The last byte of a frame always yields a result in the next cycle.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_o)
    else $error("no result after last byte");

  // Inner bytes never produce a result.
  a_inner_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !last_byte_i && !out_valid_o |=> !out_valid_o)
    else $error("result after an inner byte");

  // Input is held off only by a result that is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the result register");

endmodule

bind meter_response_frame_decoder mrfd_checker u_mrfd_checker (.*);

`default_nettype wire

// File: tb/sv/meter_reading_checker.sv
`default_nettype none

module meter_reading_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] voltage_decivolt_i,
  input  wire logic [31:0] current_milliamp_i,
  input  wire logic [31:0] power_deciwatt_i,
  input  wire logic [31:0] energy_watt_hour_i,
  input  wire logic [15:0] frequency_decihertz_i,
  input  wire logic [15:0] power_factor_hundredths_i,
  input  wire logic [15:0] alarm_word_i,
  input  wire logic        update_ok_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o,
  output int unsigned      readings_checked_o,
  output int unsigned      good_frames_o
);
  import mrfd_pkg::*;

  typedef struct packed {
    logic [15:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [15:0] frequency;
    logic [15:0] pfactor;
    logic [15:0] alarm;
    logic        ok;
  } reading_t;

  reading_t        readings_due[$];
  logic [15:0]     crc_run;
  logic [IdxW-1:0] frame_pos;
  logic [7:0]      payload_bytes[PayloadLen];
  int unsigned     mismatches = 0;
  int unsigned     pending = 0;
  int unsigned     checked = 0;
  int unsigned     good_frames = 0;

  assign mismatch_count_o   = mismatches;
  assign pending_o          = pending;
  assign readings_checked_o = checked;
  assign good_frames_o      = good_frames;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  // Big-endian register word that starts at a given frame position.
  function automatic logic [15:0] reg_word(input int unsigned frame_at);
    return {payload_bytes[frame_at - PayloadFirst], payload_bytes[frame_at - PayloadFirst + 1]};
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  task automatic compare_reading(input reading_t want, input reading_t got);
    if (want.voltage !== got.voltage) begin
      note_mismatch("voltage_decivolt", 32'(want.voltage), 32'(got.voltage));
    end
    if (want.current !== got.current) note_mismatch("current_milliamp", want.current, got.current);
    if (want.power !== got.power) note_mismatch("power_deciwatt", want.power, got.power);
    if (want.energy !== got.energy) note_mismatch("energy_watt_hour", want.energy, got.energy);
    if (want.frequency !== got.frequency) begin
      note_mismatch("frequency_decihertz", 32'(want.frequency), 32'(got.frequency));
    end
    if (want.pfactor !== got.pfactor) begin
      note_mismatch("power_factor_hundredths", 32'(want.pfactor), 32'(got.pfactor));
    end
    if (want.alarm !== got.alarm) begin
      note_mismatch("alarm_word", 32'(want.alarm), 32'(got.alarm));
    end
    if (want.ok !== got.ok) note_mismatch("update_ok", 32'(want.ok), 32'(got.ok));
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    reading_t    r;
    pos = frame_pos;
    crc_run = crc16_fold(crc_run, b);
    if (pos >= PayloadFirst && pos < PayloadFirst + PayloadLen) begin
      payload_bytes[pos - PayloadFirst] = b;
    end
    if (frame_pos != IndexMax) frame_pos = frame_pos + 1'b1;
    if (last) begin
      r = '0;
      // A frame that passes has written every payload byte itself.
      if (crc_run == 16'h0000 && pos + 1 >= MinFrame) begin
        r.voltage   = reg_word(PosVoltage);
        r.current   = {reg_word(PosCurrent + 2), reg_word(PosCurrent)};
        r.power     = {reg_word(PosPower + 2), reg_word(PosPower)};
        r.energy    = {reg_word(PosEnergy + 2), reg_word(PosEnergy)};
        r.frequency = reg_word(PosFrequency);
        r.pfactor   = reg_word(PosPfactor);
        r.alarm     = reg_word(PosAlarm);
        r.ok        = 1'b1;
        good_frames++;
      end
      readings_due.push_back(r);
      crc_run   = CrcInit;
      frame_pos = '0;
    end
  endtask

  // The result of a frame leaves in the cycle after its last byte at the earliest,
  // so the output transfer is matched before the input transfer is folded in.
  always @(posedge clk_i) begin
    reading_t got;
    if (!rst_ni) begin
      crc_run   = CrcInit;
      frame_pos = '0;
      readings_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {voltage_decivolt_i, current_milliamp_i, power_deciwatt_i, energy_watt_hour_i,
               frequency_decihertz_i, power_factor_hundredths_i, alarm_word_i, update_ok_i};
        checked++;
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: reading transfer with no frame outstanding", $realtime);
          end
        end else begin
          compare_reading(readings_due.pop_front(), got);
        end
      end
      if (in_valid_i && in_ready_i) take_byte(rx_byte_i, last_byte_i);
    end
    pending = readings_due.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
  import mrfd_pkg::*;

  localparam int unsigned ItemTarget = 1400;
  localparam int unsigned IdlePct    = 13;

  typedef enum int {FillRandom, FillZeros, FillOnes, FillExtremes} fill_e;
  typedef enum int {KindReply, KindShort, KindLong, KindCorrupt, KindNoise} frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] voltage_decivolt_o;
  logic [31:0] current_milliamp_o;
  logic [31:0] power_deciwatt_o;
  logic [31:0] energy_watt_hour_o;
  logic [15:0] frequency_decihertz_o;
  logic [15:0] power_factor_hundredths_o;
  logic [15:0] alarm_word_o;
  logic        update_ok_o;

  int unsigned mismatch_count;
  int unsigned readings_pending;
  int unsigned readings_checked;
  int unsigned good_frames;

  logic        calm = 1'b0;
  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned frame_tally[5] = '{0, 0, 0, 0, 0};

  always #10 clk_i = ~clk_i;

  meter_response_frame_decoder dut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .in_valid_i                (in_valid_i),
    .in_ready_o                (in_ready_o),
    .rx_byte_i                 (rx_byte_i),
    .last_byte_i               (last_byte_i),
    .out_valid_o               (out_valid_o),
    .out_ready_i               (out_ready_i),
    .voltage_decivolt_o        (voltage_decivolt_o),
    .current_milliamp_o        (current_milliamp_o),
    .power_deciwatt_o          (power_deciwatt_o),
    .energy_watt_hour_o        (energy_watt_hour_o),
    .frequency_decihertz_o     (frequency_decihertz_o),
    .power_factor_hundredths_o (power_factor_hundredths_o),
    .alarm_word_o              (alarm_word_o),
    .update_ok_o               (update_ok_o)
  );

  meter_reading_checker u_checker (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .in_valid_i                (in_valid_i),
    .in_ready_i                (in_ready_o),
    .rx_byte_i                 (rx_byte_i),
    .last_byte_i               (last_byte_i),
    .out_valid_i               (out_valid_o),
    .out_ready_i               (out_ready_i),
    .voltage_decivolt_i        (voltage_decivolt_o),
    .current_milliamp_i        (current_milliamp_o),
    .power_deciwatt_i          (power_deciwatt_o),
    .energy_watt_hour_i        (energy_watt_hour_o),
    .frequency_decihertz_i     (frequency_decihertz_o),
    .power_factor_hundredths_i (power_factor_hundredths_o),
    .alarm_word_i              (alarm_word_o),
    .update_ok_i               (update_ok_o),
    .mismatch_count_o          (mismatch_count),
    .pending_o                 (readings_pending),
    .readings_checked_o        (readings_checked),
    .good_frames_o             (good_frames)
  );

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Appends the CRC low byte first, which leaves a zero residual over the frame.
  task automatic append_crc();
    logic [15:0] crc;
    crc = CrcInit;
    foreach (frame_bytes[i]) begin
      crc = crc ^ {8'h00, frame_bytes[i]};
      repeat (8) begin
        crc = crc[0] ? ({1'b0, crc[15:1]} ^ CrcPoly) : {1'b0, crc[15:1]};
      end
    end
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endtask

  task automatic build_reply(input fill_e fill);
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(1, 247)));
    frame_bytes.push_back(8'h04);
    frame_bytes.push_back(8'(PayloadLen));
    repeat (PayloadLen) begin
      case (fill)
        FillZeros:    frame_bytes.push_back(8'h00);
        FillOnes:     frame_bytes.push_back(8'hFF);
        FillExtremes: frame_bytes.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        default:      frame_bytes.push_back(8'($urandom));
      endcase
    end
    append_crc();
  endtask

  task automatic build_random(input int unsigned len, input bit with_crc);
    frame_bytes.delete();
    repeat (with_crc ? len - 2 : len) frame_bytes.push_back(8'($urandom));
    if (with_crc) append_crc();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_tally[kind]++;
  endtask

  // Holds the sender off until every frame's reading has been transferred.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (readings_pending != 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned at;
    int unsigned frame_no;
    frame_kind_e kind;
    fill_e       fill;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one-byte frames at both byte extremes, then a passing reply with an all-ones payload.
    frame_bytes = '{8'h00};
    send_frame(KindNoise);
    frame_bytes = '{8'hFF};
    send_frame(KindNoise);
    build_reply(FillOnes);
    send_frame(KindReply);
    drain();

    frame_no = 0;
    while (bytes_sent < ItemTarget) begin
      calm <= (frame_no >= 12 && frame_no < 22);
      pick = $urandom_range(99);
      if (pick < 60) begin
        kind = KindReply;
        case ($urandom_range(9))
          0:       fill = FillZeros;
          1:       fill = FillOnes;
          2:       fill = FillExtremes;
          default: fill = FillRandom;
        endcase
        build_reply(fill);
      end else if (pick < 70) begin
        // Good CRC but too short; at least one frame in three is one byte short of passing.
        kind = KindShort;
        len = ($urandom_range(2) == 0) ? MinFrame - 1 : $urandom_range(2, MinFrame - 1);
        build_random(len, 1'b1);
      end else if (pick < 78) begin
        // Long frames, half of them past the point where the byte position saturates.
        kind = KindLong;
        len = $urandom_range(1) ? $urandom_range(64, 90) : $urandom_range(MinFrame, 63);
        build_random(len, 1'b1);
      end else if (pick < 90) begin
        kind = KindCorrupt;
        build_reply(FillRandom);
        at = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[at] = frame_bytes[at] ^ (8'h01 << $urandom_range(7));
      end else begin
        kind = KindNoise;
        build_random($urandom_range(1, 30), 1'b0);
      end
      send_frame(kind);
      if ($urandom_range(7) == 0) drain();
      frame_no++;
    end

    in_valid_i <= 1'b0;
    while (readings_pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d bytes in %0d frames: %0d replies, %0d short, %0d long,",
             bytes_sent, frame_tally[KindReply] + frame_tally[KindShort] + frame_tally[KindLong]
             + frame_tally[KindCorrupt] + frame_tally[KindNoise], frame_tally[KindReply],
             frame_tally[KindShort], frame_tally[KindLong]);
    $display("%0d corrupted and %0d noise; compared %0d readings, %0d of them passing.",
             frame_tally[KindCorrupt], frame_tally[KindNoise], readings_checked, good_frames);
    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
